FILE: hw/rtl/link_session_controller_core_macros.svh
// assertion helpers for the link session controller
`ifndef LINK_SESSION_CONTROLLER_CORE_MACROS_SVH
`define LINK_SESSION_CONTROLLER_CORE_MACROS_SVH

// same-cycle implication, checked out of reset
`define LSC_ASSERT_NOW(label, ck, rst_n, ante, cons) \
	label: assert property (@(posedge ck) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("link session controller check failed");

// next-cycle implication, checked out of reset
`define LSC_ASSERT_NEXT(label, ck, rst_n, ante, cons) \
	label: assert property (@(posedge ck) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("link session controller check failed");

`endif

FILE: hw/rtl/lsc_pkg.sv
package lsc_pkg;

	localparam int unsigned OP_W     = 4;
	localparam int unsigned TIME_W   = 32;
	localparam int unsigned CODE_W   = 32;
	localparam int unsigned CNT_W    = 32;
	localparam int unsigned SEQ_W    = 16;
	localparam int unsigned LSTATE_W = 2;
	localparam int unsigned CFG_IDX_W  = 2;
	localparam int unsigned CFG_DATA_W = 32;

	// link states
	typedef enum logic [LSTATE_W-1:0] {
		ST_STOPPED     = 2'd0,
		ST_WAITING     = 2'd1,
		ST_HANDSHAKING = 2'd2,
		ST_READY       = 2'd3
	} state_t;

	// event codes
	typedef enum logic [OP_W-1:0] {
		OP_RESET     = 4'd0,
		OP_STOP      = 4'd1,
		OP_HS_START  = 4'd2,
		OP_HS_DONE   = 4'd3,
		OP_DISCONNECT = 4'd4,
		OP_RX        = 4'd5,
		OP_TX        = 4'd6,
		OP_ERROR     = 4'd7,
		OP_SEQ       = 4'd8,
		OP_POLL      = 4'd9,
		OP_STATUS_SENT = 4'd10,
		OP_GPS_SENT  = 4'd11,
		OP_SET_STATE = 4'd12
	} op_t;

	// configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_HS_TIMEOUT      = 2'd0,
		CFG_STATUS_INTERVAL = 2'd1,
		CFG_GPS_INTERVAL    = 2'd2
	} cfg_idx_t;

	localparam logic [TIME_W-1:0] HS_TIMEOUT_RST      = 32'd3000;
	localparam logic [TIME_W-1:0] STATUS_INTERVAL_RST = 32'd1000;
	localparam logic [TIME_W-1:0] GPS_INTERVAL_RST    = 32'd1000;
	localparam logic [SEQ_W-1:0]  SEQ_RST             = 16'd1;

endpackage

FILE: hw/rtl/lsc_req_if.sv
interface lsc_req_if;
	logic                          valid;
	logic                          ready;
	logic [lsc_pkg::OP_W-1:0]      op;
	logic [lsc_pkg::TIME_W-1:0]    now_ms;
	logic [lsc_pkg::CODE_W-1:0]    fault_code;
	logic [lsc_pkg::LSTATE_W-1:0]  new_state;

	modport source (output valid, op, now_ms, fault_code, new_state, input ready);
	modport sink (input valid, op, now_ms, fault_code, new_state, output ready);
endinterface

FILE: hw/rtl/lsc_rsp_if.sv
interface lsc_rsp_if;
	logic                          valid;
	logic                          ready;
	logic [lsc_pkg::LSTATE_W-1:0]  link_state;
	logic [lsc_pkg::CNT_W-1:0]     rx_total;
	logic [lsc_pkg::CNT_W-1:0]     tx_total;
	logic [lsc_pkg::CODE_W-1:0]    last_fault_code;
	logic [lsc_pkg::SEQ_W-1:0]     sequence_res;
	logic                          expired;
	logic                          status_due;
	logic                          gps_due;

	modport source (output valid, link_state, rx_total, tx_total, last_fault_code,
		sequence_res, expired, status_due, gps_due, input ready);
	modport sink (input valid, link_state, rx_total, tx_total, last_fault_code,
		sequence_res, expired, status_due, gps_due, output ready);
endinterface

FILE: hw/rtl/link_session_controller_core.sv
// link session controller core
// req carries one timestamped event word per handshake (op, now_ms, fault_code,
// new_state); rsp returns one result word per event holding the session
// registers after that event plus the expired / status_due / gps_due flags.
// cfg_we / cfg_idx / cfg_data write handshake_timeout (0), status_interval (1)
// and gps_interval (2); other indexes are ignored. write only while idle.
// an accepted event passes through the input register, then the result register,
// before its result word appears on rsp.
// throughput: one event per cycle while rsp takes the result words, set by the
// combinational update of the session registers between the input register
// and the result register. when rsp stalls, one more event is taken into the
// input register; after that req.ready drops until the result word is taken.
// reset (arst_n low) empties both registers, sets the link to waiting, clears
// counters, error, deadline and timestamps, sets the sequence to one and
// loads the timeout and interval registers with 3000 / 1000 / 1000 ms.
`include "link_session_controller_core_macros.svh"

module link_session_controller_core (
	input  logic                           clk,
	input  logic                           arst_n,
	lsc_req_if.sink                        req,
	lsc_rsp_if.source                      rsp,
	input  logic                           cfg_we,
	input  logic [lsc_pkg::CFG_IDX_W-1:0]  cfg_idx,
	input  logic [lsc_pkg::CFG_DATA_W-1:0] cfg_data
);
	import lsc_pkg::*;

	// configuration
	logic [TIME_W-1:0] hs_timeout_q, status_interval_q, gps_interval_q;

	// input stage
	logic                v_s1;
	logic [OP_W-1:0]     op_s1;
	logic [TIME_W-1:0]   now_s1;
	logic [CODE_W-1:0]   code_s1;
	logic [LSTATE_W-1:0] new_state_s1;

	// session registers
	state_t            state_q, state_d;
	logic [CNT_W-1:0]  rx_q, rx_d, tx_q, tx_d;
	logic [CODE_W-1:0] error_q, error_d;
	logic [SEQ_W-1:0]  seq_q, seq_d;
	logic [TIME_W-1:0] deadline_q, deadline_d;
	logic [TIME_W-1:0] status_time_q, status_time_d, gps_time_q, gps_time_d;
	logic              expired_d, status_due_d, gps_due_d;
	logic              status_elapsed, gps_elapsed;

	// result register
	logic                rsp_v_q;
	state_t              link_state_q;
	logic [CNT_W-1:0]    rx_total_q, tx_total_q;
	logic [CODE_W-1:0]   last_error_q;
	logic [SEQ_W-1:0]    sequence_q;
	logic                expired_q, status_due_q, gps_due_q;

	logic s1_move, s1_fire, req_fire;

	assign s1_move   = !rsp_v_q || rsp.ready;
	assign s1_fire   = v_s1 && s1_move;
	assign req.ready = !v_s1 || s1_move;
	assign req_fire  = req.valid && req.ready;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hs_timeout_q      <= HS_TIMEOUT_RST;
			status_interval_q <= STATUS_INTERVAL_RST;
			gps_interval_q    <= GPS_INTERVAL_RST;
		end else if (cfg_we) begin
			case (cfg_idx)
				CFG_HS_TIMEOUT:      hs_timeout_q      <= cfg_data;
				CFG_STATUS_INTERVAL: status_interval_q <= cfg_data;
				CFG_GPS_INTERVAL:    gps_interval_q    <= cfg_data;
				default: ;
			endcase
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (req.ready) begin
			v_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req_fire) begin
			op_s1        <= req.op;
			now_s1       <= req.now_ms;
			code_s1      <= req.fault_code;
			new_state_s1 <= req.new_state;
		end
	end

	// wrapping elapsed-time checks
	assign status_elapsed = (now_s1 - status_time_q) >= status_interval_q;
	assign gps_elapsed    = (now_s1 - gps_time_q) >= gps_interval_q;

	// next session state
	always_comb begin
		state_d       = state_q;
		rx_d          = rx_q;
		tx_d          = tx_q;
		error_d       = error_q;
		seq_d         = seq_q;
		deadline_d    = deadline_q;
		status_time_d = status_time_q;
		gps_time_d    = gps_time_q;
		case (op_s1)
			OP_RESET: begin
				state_d       = ST_WAITING;
				rx_d          = '0;
				tx_d          = '0;
				error_d       = '0;
				seq_d         = SEQ_RST;
				deadline_d    = '0;
				status_time_d = now_s1;
				gps_time_d    = now_s1;
			end
			OP_STOP: begin
				state_d    = ST_STOPPED;
				deadline_d = '0;
			end
			OP_HS_START: begin
				state_d    = ST_HANDSHAKING;
				deadline_d = now_s1 + hs_timeout_q;
			end
			OP_HS_DONE: begin
				state_d       = ST_READY;
				deadline_d    = '0;
				status_time_d = now_s1;
				gps_time_d    = now_s1;
			end
			OP_DISCONNECT: begin
				state_d    = ST_WAITING;
				deadline_d = '0;
			end
			OP_RX:    rx_d    = rx_q + CNT_W'(1);
			OP_TX:    tx_d    = tx_q + CNT_W'(1);
			OP_ERROR: error_d = code_s1;
			OP_SEQ: begin
				// sequence skips zero on wrap
				seq_d = (seq_q == {SEQ_W{1'b1}}) ? SEQ_RST : seq_q + SEQ_W'(1);
			end
			OP_POLL: begin
				if (expired_d) begin
					state_d    = ST_WAITING;
					deadline_d = '0;
				end
			end
			OP_STATUS_SENT: status_time_d = now_s1;
			OP_GPS_SENT:    gps_time_d    = now_s1;
			OP_SET_STATE:   state_d       = state_t'(new_state_s1);
			default: ;
		endcase
	end

	// poll flags; an expiring poll leaves waiting, so no flag is due then
	always_comb begin
		expired_d    = 1'b0;
		status_due_d = 1'b0;
		gps_due_d    = 1'b0;
		case (op_s1)
			OP_POLL: begin
				expired_d = (state_q == ST_HANDSHAKING) && (deadline_q != '0)
					&& (now_s1 > deadline_q);
				status_due_d = (state_q == ST_READY) && status_elapsed;
				gps_due_d    = (state_q == ST_READY) && gps_elapsed;
			end
			default: ;
		endcase
	end

	// session registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_WAITING;
			rx_q          <= '0;
			tx_q          <= '0;
			error_q       <= '0;
			seq_q         <= SEQ_RST;
			deadline_q    <= '0;
			status_time_q <= '0;
			gps_time_q    <= '0;
		end else if (s1_fire) begin
			state_q       <= state_d;
			rx_q          <= rx_d;
			tx_q          <= tx_d;
			error_q       <= error_d;
			seq_q         <= seq_d;
			deadline_q    <= deadline_d;
			status_time_q <= status_time_d;
			gps_time_q    <= gps_time_d;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_v_q <= 1'b0;
		end else if (s1_move) begin
			rsp_v_q <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_fire) begin
			link_state_q <= state_d;
			rx_total_q   <= rx_d;
			tx_total_q   <= tx_d;
			last_error_q <= error_d;
			sequence_q   <= seq_d;
			expired_q    <= expired_d;
			status_due_q <= status_due_d;
			gps_due_q    <= gps_due_d;
		end
	end

	assign rsp.valid           = rsp_v_q;
	assign rsp.link_state      = link_state_q;
	assign rsp.rx_total        = rx_total_q;
	assign rsp.tx_total        = tx_total_q;
	assign rsp.last_fault_code = last_error_q;
	assign rsp.sequence_res    = sequence_q;
	assign rsp.expired         = expired_q;
	assign rsp.status_due      = status_due_q;
	assign rsp.gps_due         = gps_due_q;

	// checks
	`LSC_ASSERT_NOW(a_seq_nonzero, clk, arst_n, 1'b1, seq_q != '0)
	`LSC_ASSERT_NOW(a_expired_waits, clk, arst_n, rsp_v_q && expired_q,
		(link_state_q == ST_WAITING) && !status_due_q && !gps_due_q)
	`LSC_ASSERT_NOW(a_due_ready, clk, arst_n, rsp_v_q && (status_due_q || gps_due_q),
		link_state_q == ST_READY)
	`LSC_ASSERT_NOW(a_full_stall, clk, arst_n, v_s1 && rsp_v_q && !rsp.ready, !req.ready)
	`LSC_ASSERT_NEXT(a_rx_count, clk, arst_n, s1_fire && (op_s1 == OP_RX),
		rx_q == $past(rx_q) + CNT_W'(1))

endmodule
